### hw/rtl/partial_register_file_alu_assert.svh
// assertion macros used by the register file alu top level
`ifndef PARTIAL_REGISTER_FILE_ALU_ASSERT_SVH
`define PARTIAL_REGISTER_FILE_ALU_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PRFA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define PRFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/prfa_pkg.sv
// shared types and codes for the register file alu
`timescale 1ns / 1ps

package prfa_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_SHOW_REG = 3'd1,
        CMD_SHOW_IMM = 3'd2,
        CMD_MOV      = 3'd3,
        CMD_ADD      = 3'd4,
        CMD_SUB      = 3'd5
    } cmd_t;

    localparam logic [3:0] SEL_EAX = 4'd0;
    localparam logic [3:0] SEL_ECX = 4'd1;
    localparam logic [3:0] SEL_EDX = 4'd2;
    localparam logic [3:0] SEL_EIP = 4'd3;
    localparam logic [3:0] SEL_AX  = 4'd4;
    localparam logic [3:0] SEL_CX  = 4'd5;
    localparam logic [3:0] SEL_DX  = 4'd6;
    localparam logic [3:0] SEL_AL  = 4'd7;
    localparam logic [3:0] SEL_AH  = 4'd8;
    localparam logic [3:0] SEL_CL  = 4'd9;
    localparam logic [3:0] SEL_CH  = 4'd10;
    localparam logic [3:0] SEL_DL  = 4'd11;
    localparam logic [3:0] SEL_DH  = 4'd12;

    // decoded operation kind carried from front to back
    typedef enum logic [2:0] {
        K_NONE,
        K_SHOW_EIP,
        K_SHOW_REG,
        K_SHOW_IMM,
        K_MOV,
        K_ADD,
        K_SUB,
        K_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        BASE_A,
        BASE_C,
        BASE_D
    } base_t;

    typedef enum logic [1:0] {
        PART_DWORD,
        PART_WORD,
        PART_LOW,
        PART_HIGH
    } part_t;

    typedef struct packed {
        logic  ok;
        base_t base;
        part_t part;
    } sel_info_t;

    typedef struct packed {
        kind_t              kind;
        base_t              dst_base;
        part_t              dst_part;
        logic               src_imm;
        base_t              src_base;
        part_t              src_part;
        logic [DATA_W-1:0]  imm;
    } uop_t;

endpackage

### hw/rtl/prfa_front.sv
// front end: input handshake and instruction decode
`timescale 1ns / 1ps

module prfa_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_command,
    input  logic [3:0]           s_dest_sel,
    input  logic                 s_source_is_immediate,
    input  logic [3:0]           s_source_sel,
    input  logic [31:0]          s_immediate,
    input  logic                 q_full,
    output logic                 q_push,
    output prfa_pkg::uop_t       q_push_data
);
    import prfa_pkg::*;

    function automatic sel_info_t decode_sel(input logic [3:0] sel);
        sel_info_t info;
        info.ok   = 1'b1;
        info.base = BASE_A;
        info.part = PART_DWORD;
        case (sel)
            SEL_EAX: begin info.base = BASE_A; info.part = PART_DWORD; end
            SEL_ECX: begin info.base = BASE_C; info.part = PART_DWORD; end
            SEL_EDX: begin info.base = BASE_D; info.part = PART_DWORD; end
            SEL_AX:  begin info.base = BASE_A; info.part = PART_WORD;  end
            SEL_CX:  begin info.base = BASE_C; info.part = PART_WORD;  end
            SEL_DX:  begin info.base = BASE_D; info.part = PART_WORD;  end
            SEL_AL:  begin info.base = BASE_A; info.part = PART_LOW;   end
            SEL_AH:  begin info.base = BASE_A; info.part = PART_HIGH;  end
            SEL_CL:  begin info.base = BASE_C; info.part = PART_LOW;   end
            SEL_CH:  begin info.base = BASE_C; info.part = PART_HIGH;  end
            SEL_DL:  begin info.base = BASE_D; info.part = PART_LOW;   end
            SEL_DH:  begin info.base = BASE_D; info.part = PART_HIGH;  end
            default: info.ok = 1'b0;   // eip and undefined codes
        endcase
        return info;
    endfunction

    sel_info_t dst_info;
    sel_info_t src_info;
    logic      bad_operand;
    kind_t     kind;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        dst_info    = decode_sel(s_dest_sel);
        src_info    = decode_sel(s_source_sel);
        bad_operand = !dst_info.ok || (!s_source_is_immediate && !src_info.ok);
        case (cmd_t'(s_command))
            CMD_SHOW_REG: begin
                if (s_dest_sel == SEL_EIP) begin
                    kind = K_SHOW_EIP;
                end else if (dst_info.ok) begin
                    kind = K_SHOW_REG;
                end else begin
                    kind = K_NONE;
                end
            end
            CMD_SHOW_IMM: kind = K_SHOW_IMM;
            CMD_MOV:      kind = bad_operand ? K_ERROR : K_MOV;
            CMD_ADD:      kind = bad_operand ? K_ERROR : K_ADD;
            CMD_SUB:      kind = bad_operand ? K_ERROR : K_SUB;
            default:      kind = K_NONE;
        endcase
    end

    always_comb begin
        q_push_data.kind     = kind;
        q_push_data.dst_base = dst_info.base;
        q_push_data.dst_part = dst_info.part;
        q_push_data.src_imm  = s_source_is_immediate;
        q_push_data.src_base = src_info.base;
        q_push_data.src_part = src_info.part;
        q_push_data.imm      = s_immediate;
    end

endmodule

### hw/rtl/prfa_queue.sv
// small fifo of decoded operations between front and back
`timescale 1ns / 1ps

module prfa_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  prfa_pkg::uop_t  push_data,
    output logic            full,
    input  logic            pop,
    output prfa_pkg::uop_t  pop_data,
    output logic            empty
);
    import prfa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    uop_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/prfa_back.sv
// back end: register file, counter, alu and result register
`timescale 1ns / 1ps

module prfa_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  prfa_pkg::uop_t  q_pop_data,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_show_valid,
    output logic [31:0]     m_show_value,
    output logic            m_error
);
    import prfa_pkg::*;

    function automatic logic [DATA_W-1:0] read_part(input logic [DATA_W-1:0] v,
                                                    input part_t part);
        logic [DATA_W-1:0] r;
        case (part)
            PART_DWORD: r = v;
            PART_WORD:  r = {16'd0, v[15:0]};
            PART_LOW:   r = {24'd0, v[7:0]};
            PART_HIGH:  r = {24'd0, v[15:8]};
            default:    r = v;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] write_part(input logic [DATA_W-1:0] old,
                                                     input part_t part,
                                                     input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] r;
        case (part)
            PART_DWORD: r = val;
            PART_WORD:  r = {old[31:16], val[15:0]};
            PART_LOW:   r = {old[31:8], val[7:0]};
            PART_HIGH:  r = {old[31:16], val[7:0], old[7:0]};
            default:    r = val;
        endcase
        return r;
    endfunction

    logic [DATA_W-1:0] reg_a_reg, reg_a_next;
    logic [DATA_W-1:0] reg_c_reg, reg_c_next;
    logic [DATA_W-1:0] reg_d_reg, reg_d_next;
    logic [DATA_W-1:0] count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    logic              show_valid_reg, show_valid_next;
    logic [DATA_W-1:0] show_value_reg, show_value_next;
    logic              error_reg, error_next;

    logic [DATA_W-1:0] dst_full;
    logic [DATA_W-1:0] src_full;
    logic [DATA_W-1:0] dst_val;
    logic [DATA_W-1:0] src_val;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] merged;
    logic              do_write;

    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    // operand fetch and alu
    always_comb begin
        case (q_pop_data.dst_base)
            BASE_A:  dst_full = reg_a_reg;
            BASE_C:  dst_full = reg_c_reg;
            default: dst_full = reg_d_reg;
        endcase
        case (q_pop_data.src_base)
            BASE_A:  src_full = reg_a_reg;
            BASE_C:  src_full = reg_c_reg;
            default: src_full = reg_d_reg;
        endcase
        dst_val = read_part(dst_full, q_pop_data.dst_part);
        src_val = q_pop_data.src_imm ? q_pop_data.imm
                                     : read_part(src_full, q_pop_data.src_part);
        case (q_pop_data.kind)
            K_ADD:   alu_res = dst_val + src_val;
            K_SUB:   alu_res = dst_val - src_val;
            default: alu_res = src_val;
        endcase
        merged   = write_part(dst_full, q_pop_data.dst_part, alu_res);
        do_write = q_pop && (q_pop_data.kind == K_MOV || q_pop_data.kind == K_ADD
                             || q_pop_data.kind == K_SUB);
    end

    always_comb begin
        reg_a_next = reg_a_reg;
        reg_c_next = reg_c_reg;
        reg_d_next = reg_d_reg;
        if (do_write) begin
            case (q_pop_data.dst_base)
                BASE_A:  reg_a_next = merged;
                BASE_C:  reg_c_next = merged;
                default: reg_d_next = merged;
            endcase
        end
        count_next = q_pop ? count_reg + 1'b1 : count_reg;
    end

    // result register
    always_comb begin
        m_valid_next    = m_valid_reg;
        show_valid_next = show_valid_reg;
        show_value_next = show_value_reg;
        error_next      = error_reg;
        if (q_pop) begin
            m_valid_next    = 1'b1;
            show_valid_next = 1'b0;
            show_value_next = '0;
            error_next      = 1'b0;
            case (q_pop_data.kind)
                K_SHOW_EIP: begin
                    show_valid_next = 1'b1;
                    show_value_next = count_reg + 1'b1;
                end
                K_SHOW_REG: begin
                    show_valid_next = 1'b1;
                    show_value_next = dst_val;
                end
                K_SHOW_IMM: begin
                    show_valid_next = 1'b1;
                    show_value_next = q_pop_data.imm;
                end
                K_ERROR: error_next = 1'b1;
                default: ;
            endcase
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_a_reg   <= '0;
            reg_c_reg   <= '0;
            reg_d_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            reg_a_reg   <= reg_a_next;
            reg_c_reg   <= reg_c_next;
            reg_d_reg   <= reg_d_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        show_valid_reg <= show_valid_next;
        show_value_reg <= show_value_next;
        error_reg      <= error_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_show_valid = show_valid_reg;
    assign m_show_value = show_value_reg;
    assign m_error      = error_reg;

endmodule

### hw/rtl/partial_register_file_alu.sv
// top level of the partial register file alu
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------------
//  s_      | in        | s_valid s_ready s_command s_dest_sel s_source_is_immediate
//          |           | s_source_sel s_immediate
//  m_      | out       | m_valid m_ready m_show_valid m_show_value m_error
//
// one transfer in and one transfer out per cycle when neither side stalls
// result passes the queue entry, then the result register: decode into the queue, then execute
// the back end executes one entry per cycle while the output is not stalled; eax/ecx/edx and the counter live there
// aresetn clears the registers, counter, queue pointers and output valid
// an output stall fills the queue, then s_ready drops until the result is taken
`timescale 1ns / 1ps
`include "partial_register_file_alu_assert.svh"

module partial_register_file_alu #(
    parameter int QUEUE_DEPTH = 2     // at least 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [3:0]  s_dest_sel,
    input  logic        s_source_is_immediate,
    input  logic [3:0]  s_source_sel,
    input  logic [31:0] s_immediate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_show_valid,
    output logic [31:0] m_show_value,
    output logic        m_error
);
    import prfa_pkg::*;

    // decoded operation path between front and back
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    uop_t q_push_data;
    uop_t q_pop_data;

    // front: handshake and decode of selectors and command
    prfa_front u_front (
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_command             (s_command),
        .s_dest_sel            (s_dest_sel),
        .s_source_is_immediate (s_source_is_immediate),
        .s_source_sel          (s_source_sel),
        .s_immediate           (s_immediate),
        .q_full                (q_full),
        .q_push                (q_push),
        .q_push_data           (q_push_data)
    );

    // decouples accept from execute so each side stalls alone
    prfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // back: executes in order, counter bumps on every executed entry
    prfa_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop_data   (q_pop_data),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_show_valid (m_show_valid),
        .m_show_value (m_show_value),
        .m_error      (m_error)
    );

    // a show and an error never come from the same item
    `PRFA_ASSERT_IMPL(a_show_err_excl, aclk, aresetn, m_valid && m_show_valid, !m_error)
    // nothing shown means a zero value
    `PRFA_ASSERT_IMPL(a_show_zero, aclk, aresetn, m_valid && !m_show_valid, m_show_value == '0)
    // an accepted transfer always lands in the queue
    `PRFA_ASSERT_NEXT(a_push_lands, aclk, aresetn, s_valid && s_ready, !q_empty)

endmodule

### tb/sv/tb.sv
// self-checking testbench for the partial register file alu
`timescale 1ns / 1ps

module tb;
    import prfa_pkg::*;

    // codes outside the defined command and selector sets
    localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
    localparam logic [3:0] SEL_UNDEF_LO = 4'd13;
    localparam logic [3:0] SEL_UNDEF_HI = 4'd15;

    // no data register behind a selector
    localparam int NO_GPR = 3;

    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // drain time after the last result
    localparam int DRAIN_CYCLES = 16;
    localparam int ITEMS_PER_PHASE = 325;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  dest;
        logic        src_imm;
        logic [3:0]  src;
        logic [31:0] imm;
    } instr_t;

    typedef struct packed {
        logic        show_valid;
        logic [31:0] show_value;
        logic        error;
    } result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [3:0]  s_dest_sel;
    logic        s_source_is_immediate;
    logic [3:0]  s_source_sel;
    logic [31:0] s_immediate;
    logic        m_valid;
    logic        m_ready;
    logic        m_show_valid;
    logic [31:0] m_show_value;
    logic        m_error;

    // instructions waiting to be driven, and results the block still owes
    instr_t  pending_instrs[$];
    result_t owed_results[$];

    // shadow architectural state: eax, ecx, edx and the instruction counter
    logic [31:0] shadow_gpr [0:2];
    logic [31:0] shadow_eip;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        in_taken;
    instr_t      drive_instr;
    int unsigned quiet_cycles;
    int unsigned fail_count;
    int unsigned instrs_sent;
    int unsigned results_checked;
    int unsigned shows_seen;
    int unsigned faults_seen;

    partial_register_file_alu DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_command             (s_command),
        .s_dest_sel            (s_dest_sel),
        .s_source_is_immediate (s_source_is_immediate),
        .s_source_sel          (s_source_sel),
        .s_immediate           (s_immediate),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_show_valid          (m_show_valid),
        .m_show_value          (m_show_value),
        .m_error               (m_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // which of eax/ecx/edx a selector reaches
    function automatic int gpr_index(logic [3:0] sel);
        case (sel)
            SEL_EAX, SEL_AX, SEL_AL, SEL_AH: return 0;
            SEL_ECX, SEL_CX, SEL_CL, SEL_CH: return 1;
            SEL_EDX, SEL_DX, SEL_DL, SEL_DH: return 2;
            default: return NO_GPR;
        endcase
    endfunction

    function automatic logic [31:0] part_mask(logic [3:0] sel);
        case (sel)
            SEL_EAX, SEL_ECX, SEL_EDX: return 32'hFFFF_FFFF;
            SEL_AX, SEL_CX, SEL_DX:    return 32'h0000_FFFF;
            default:                   return 32'h0000_00FF;
        endcase
    endfunction

    // high byte parts sit at bit 8
    function automatic int part_shift(logic [3:0] sel);
        return (sel == SEL_AH || sel == SEL_CH || sel == SEL_DH) ? 8 : 0;
    endfunction

    function automatic logic [31:0] read_gpr_part(logic [3:0] sel);
        return (shadow_gpr[gpr_index(sel)] >> part_shift(sel)) & part_mask(sel);
    endfunction

    function automatic void write_gpr_part(logic [3:0] sel, logic [31:0] value);
        logic [31:0] m;
        int          idx;
        idx = gpr_index(sel);
        m = part_mask(sel) << part_shift(sel);
        shadow_gpr[idx] = (shadow_gpr[idx] & ~m) | ((value << part_shift(sel)) & m);
    endfunction

    // executes one instruction on the shadow state, returns what the block must answer
    function automatic result_t execute_instr(instr_t it);
        result_t     r;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] res;
        r = '0;
        shadow_eip = shadow_eip + 32'd1;
        case (it.cmd)
            CMD_SHOW_REG: begin
                if (it.dest == SEL_EIP) begin
                    r.show_valid = 1'b1;
                    r.show_value = shadow_eip;
                end else if (gpr_index(it.dest) != NO_GPR) begin
                    r.show_valid = 1'b1;
                    r.show_value = read_gpr_part(it.dest);
                end
            end
            CMD_SHOW_IMM: begin
                r.show_valid = 1'b1;
                r.show_value = it.imm;
            end
            CMD_MOV, CMD_ADD, CMD_SUB: begin
                if (gpr_index(it.dest) == NO_GPR
                        || (!it.src_imm && gpr_index(it.src) == NO_GPR)) begin
                    r.error = 1'b1;
                end else begin
                    opb = it.src_imm ? it.imm : read_gpr_part(it.src);
                    opa = read_gpr_part(it.dest);
                    if (it.cmd == CMD_MOV) res = opb;
                    else if (it.cmd == CMD_ADD) res = opa + opb;
                    else res = opa - opb;
                    write_gpr_part(it.dest, res);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic instr_t make_instr(logic [2:0] cmd, logic [3:0] dest, logic src_imm,
                                          logic [3:0] src, logic [31:0] imm);
        instr_t it;
        it.cmd = cmd;
        it.dest = dest;
        it.src_imm = src_imm;
        it.src = src;
        it.imm = imm;
        return it;
    endfunction

    // mostly real data parts, sometimes the counter or an undefined code
    function automatic logic [3:0] rand_sel();
        int unsigned r;
        logic [3:0]  s;
        r = $urandom_range(99);
        if (r < 5) return SEL_EIP;
        if (r < 10) return 4'($urandom_range(SEL_UNDEF_LO, SEL_UNDEF_HI));
        s = 4'($urandom_range(SEL_AX, SEL_DH + 3));
        if (s > SEL_DH) s = s - SEL_DH - 4'd1;   // folds onto eax/ecx/edx
        return s;
    endfunction

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(255));
            3: return 32'h0000_00FF;
            4: return 32'h0000_FFFF;
            5: return 32'h8000_0000 | 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t rand_instr();
        int unsigned r;
        logic [2:0]  cmd;
        r = $urandom_range(99);
        if (r < 4) cmd = CMD_NONE;
        else if (r < 8) cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        else if (r < 22) cmd = CMD_SHOW_REG;
        else if (r < 28) cmd = CMD_SHOW_IMM;
        else if (r < 52) cmd = CMD_MOV;
        else if (r < 76) cmd = CMD_ADD;
        else cmd = CMD_SUB;
        return make_instr(cmd, rand_sel(), 1'($urandom_range(1)), rand_sel(), rand_imm());
    endfunction

    // driver: inputs move at the falling edge; valid holds until the transfer happens
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !in_taken)) begin
            if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_instr = pending_instrs.pop_front();
                s_valid <= 1'b1;
                s_command <= drive_instr.cmd;
                s_dest_sel <= drive_instr.dest;
                s_source_is_immediate <= drive_instr.src_imm;
                s_source_sel <= drive_instr.src;
                s_immediate <= drive_instr.imm;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: results are checked first, so a same-edge input transfer never
    // gets ahead of the result it follows
    always @(posedge aclk) begin
        in_taken = s_valid && s_ready;
        if (!aresetn) begin
            in_taken = 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    fail_count++;
                end else begin
                    result_t exp_r;
                    exp_r = owed_results.pop_front();
                    if (m_show_valid !== exp_r.show_valid) begin
                        $error("show_valid expected %0b got %0b", exp_r.show_valid,
                               m_show_valid);
                        fail_count++;
                    end
                    if (m_show_value !== exp_r.show_value) begin
                        $error("show_value expected %h got %h", exp_r.show_value,
                               m_show_value);
                        fail_count++;
                    end
                    if (m_error !== exp_r.error) begin
                        $error("error expected %0b got %0b", exp_r.error, m_error);
                        fail_count++;
                    end
                    results_checked++;
                    if (exp_r.show_valid) shows_seen++;
                    if (exp_r.error) faults_seen++;
                end
            end
            if (in_taken) begin
                owed_results.push_back(execute_instr(make_instr(s_command, s_dest_sel,
                    s_source_is_immediate, s_source_sel, s_immediate)));
                instrs_sent++;
            end
            if ((m_valid && m_ready) || in_taken) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: nothing moved for too long
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned n;
        // every input at a known level from time zero
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_NONE;
        s_dest_sel = SEL_EAX;
        s_source_is_immediate = 1'b0;
        s_source_sel = SEL_EAX;
        s_immediate = '0;
        m_ready = 1'b0;
        in_taken = 1'b0;
        quiet_cycles = 0;
        fail_count = 0;
        instrs_sent = 0;
        results_checked = 0;
        shows_seen = 0;
        faults_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_gpr[0] = '0;
        shadow_gpr[1] = '0;
        shadow_gpr[2] = '0;
        shadow_eip = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset values, field extremes, partial writes with wrap,
        // counter and undefined operands, undefined commands
        pending_instrs.push_back(make_instr(CMD_SHOW_REG, SEL_EAX, 1'b0, SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_SHOW_REG, SEL_EIP, 1'b0, SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_SHOW_IMM, SEL_EAX, 1'b0, SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_SHOW_IMM, SEL_DH, 1'b1, SEL_UNDEF_HI,
                                            32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(CMD_MOV, SEL_EAX, 1'b1, SEL_EAX, 32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(CMD_ADD, SEL_AL, 1'b1, SEL_EAX, 32'd1));
        pending_instrs.push_back(make_instr(CMD_SUB, SEL_AH, 1'b1, SEL_EAX, 32'd1));
        pending_instrs.push_back(make_instr(CMD_MOV, SEL_ECX, 1'b0, SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_ADD, SEL_CX, 1'b0, SEL_AH, '0));
        pending_instrs.push_back(make_instr(CMD_SUB, SEL_DX, 1'b0, SEL_CL, '0));
        pending_instrs.push_back(make_instr(CMD_MOV, SEL_DH, 1'b1, SEL_EAX, 32'h1234_ABCD));
        pending_instrs.push_back(make_instr(CMD_ADD, SEL_EDX, 1'b0, SEL_EDX, '0));
        pending_instrs.push_back(make_instr(CMD_SUB, SEL_EAX, 1'b0, SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_MOV, SEL_EIP, 1'b1, SEL_EAX, 32'h5));
        pending_instrs.push_back(make_instr(CMD_ADD, SEL_ECX, 1'b0, SEL_EIP, '0));
        pending_instrs.push_back(make_instr(CMD_MOV, SEL_UNDEF_LO, 1'b1, SEL_EAX, 32'h7));
        pending_instrs.push_back(make_instr(CMD_SUB, SEL_EAX, 1'b0, SEL_UNDEF_HI, '0));
        pending_instrs.push_back(make_instr(CMD_MOV, SEL_ECX, 1'b1, SEL_UNDEF_HI,
                                            32'hDEAD_BEEF));
        pending_instrs.push_back(make_instr(CMD_SHOW_REG, 4'(SEL_UNDEF_HI - 4'd1), 1'b0,
                                            SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_UNDEF_LO, SEL_EAX, 1'b1, SEL_EAX, 32'h1));
        pending_instrs.push_back(make_instr(CMD_UNDEF_HI, SEL_UNDEF_HI, 1'b1, SEL_UNDEF_HI,
                                            32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(CMD_NONE, SEL_UNDEF_HI, 1'b1, SEL_UNDEF_HI,
                                            32'hFFFF_FFFF));
        pending_instrs.push_back(make_instr(CMD_SHOW_REG, SEL_DH, 1'b0, SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_SHOW_REG, SEL_CH, 1'b0, SEL_EAX, '0));
        pending_instrs.push_back(make_instr(CMD_SHOW_REG, SEL_EIP, 1'b0, SEL_EAX, '0));

        // phases: free running, idle sender, stalling receiver, light noise on both
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) pending_instrs.push_back(rand_instr());
            while (pending_instrs.size() != 0 || s_valid) @(posedge aclk);
            // sender holds off until the pipeline has emptied completely
            while (owed_results.size() != 0) @(posedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d instructions over four handshake phases, checked %0d results",
                 instrs_sent, results_checked);
        $display("of those %0d showed a value and %0d were rejected operands",
                 shows_seen, faults_seen);
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### partial_register_file_alu.f
+incdir+hw/rtl
hw/rtl/prfa_pkg.sv
hw/rtl/prfa_front.sv
hw/rtl/prfa_queue.sv
hw/rtl/prfa_back.sv
hw/rtl/partial_register_file_alu.sv
tb/sv/tb.sv
